// ===== src/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Command and vertex types, register indexes and the back-end state codes.
// ----------------------------------------------------------------------------
package pip_pkg;

   // default polygon capacity
   localparam int MAX_VERTICES_DEF = 16;

   // fixed field widths
   localparam int COORD_W    = 32;
   localparam int IDX_W      = 4;
   localparam int VC_W       = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // depth of the queues between the parts (power of two)
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_EN    = CSR_IDX_W'(1);

   // register reset values
   localparam logic [VC_W-1:0] VERTEX_COUNT_RST = VC_W'(4);
   localparam logic            REGION_EN_RST    = 1'b1;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TEST  = 1'b1;

   // command kinds decided by the front end
   typedef enum logic [1:0] {
      CMD_WRITE,   // store a vertex
      CMD_SKIP,    // vertex write outside the table, dropped
      CMD_PASS,    // query with checking off, answers inside
      CMD_TEST     // query that walks the polygon
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [IDX_W-1:0]           vertex_index;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } back_state_type;

   // sequencer to edge pipeline
   typedef struct packed {
      logic vld;     // a vertex enters
      logic first;   // first vertex of the walk, no edge yet
   } edge_req_type;

   // edge pipeline to sequencer
   typedef struct packed {
      logic busy;
      logic hit_vld;
      logic hit;
   } edge_rsp_type;

endpackage

// ===== src/point_in_polygon_test.sv =====
// Vertex write: queued, then stored by the back end when it takes the command.
// Query over n vertices: n+1 table reads through the edge pipeline, drain and
// push; the back end takes no new command until the query's result is pushed.
// Pass-through query (checking off) answers inside; n = 0 answers outside.
// Reset: vertex_count 4, checking on, queues empty; vertex memory is not cleared.
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number point-in-polygon test
// Front end decodes requests and holds the registers, a command queue feeds
// the back end that stores vertices and evaluates queries, results queue out.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request queue
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_operation,
   input  logic [pip_pkg::IDX_W-1:0]           req_vertex_index,
   input  logic signed [pip_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [pip_pkg::COORD_W-1:0]  req_coord_y,
   // result queue
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_inside_res,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pip_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pip_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CmdW = $bits(pip_pkg::cmd_type);

   pip_pkg::cmd_type         cmd_in, cmd_out;
   logic [CmdW-1:0]          cmd_dout;
   logic                     cmd_push, cmd_pop, cmd_empty;
   logic [pip_pkg::VC_W-1:0] vertex_count;
   logic                     res_push, res_full, res_inside;

   pip_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_operation    (req_operation),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd_push         (cmd_push),
      .cmd              (cmd_in),
      .vertex_count     (vertex_count)
   );

   // command queue between front and back
   pip_fifo #(
      .WIDTH (CmdW)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .dout  (cmd_dout),
      .empty (cmd_empty)
   );

   assign cmd_out = pip_pkg::cmd_type'(cmd_dout);

   pip_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_empty),
      .cmd          (cmd_out),
      .cmd_pop      (cmd_pop),
      .vertex_count (vertex_count),
      .res_full     (res_full),
      .res_push     (res_push),
      .res_inside   (res_inside)
   );

   // result queue
   pip_fifo #(
      .WIDTH (1)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_inside),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (rsp_inside_res),
      .empty (rsp_empty)
   );

endmodule

// ===== src/pip_fifo.sv =====
// ----------------------------------------------------------------------------
// pip_fifo: small synchronous queue
// Decouples the front end from the back end and the back end from the
// result port. Depth is a power of two so the pointers wrap on their own.
// ----------------------------------------------------------------------------
module pip_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int Depth = pip_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   logic [WIDTH-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_ok) - CntW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== src/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front: request decode and configuration registers
// Holds the control registers and classifies each request into a command
// for the back end: vertex store, dropped store, pass-through or full test.
// ----------------------------------------------------------------------------
module pip_front #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_push,
   input  logic                                  req_operation,
   input  logic [pip_pkg::IDX_W-1:0]             req_vertex_index,
   input  logic signed [pip_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [pip_pkg::COORD_W-1:0]    req_coord_y,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pip_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pip_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // command queue side
   output logic                                  cmd_push,
   output pip_pkg::cmd_type                      cmd,
   output logic [pip_pkg::VC_W-1:0]              vertex_count
);

   logic [pip_pkg::VC_W-1:0] vertex_count_ff, vertex_count_in;
   logic                     region_en_ff, region_en_in;
   logic                     in_range;

   assign csr_ready    = 1'b1;
   assign vertex_count = vertex_count_ff;
   assign cmd_push     = req_push;

   // register writes, unknown indexes are dropped
   always_comb begin
      vertex_count_in = vertex_count_ff;
      region_en_in    = region_en_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pip_pkg::CSR_VERTEX_COUNT: vertex_count_in = csr_wdata[pip_pkg::VC_W-1:0];
            pip_pkg::CSR_REGION_EN:    region_en_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= pip_pkg::VERTEX_COUNT_RST;
         region_en_ff    <= pip_pkg::REGION_EN_RST;
      end else begin
         vertex_count_ff <= vertex_count_in;
         region_en_ff    <= region_en_in;
      end
   end

   // classify the request
   assign in_range = (32'(req_vertex_index) < 32'(MAX_VERTICES));

   always_comb begin
      cmd.vertex_index = req_vertex_index;
      cmd.coord_x      = req_coord_x;
      cmd.coord_y      = req_coord_y;
      if (req_operation == pip_pkg::OP_WRITE) begin
         cmd.kind = in_range ? pip_pkg::CMD_WRITE : pip_pkg::CMD_SKIP;
      end else begin
         cmd.kind = region_en_ff ? pip_pkg::CMD_TEST : pip_pkg::CMD_PASS;
      end
   end

endmodule

// ===== src/pip_edge.sv =====
// ----------------------------------------------------------------------------
// pip_edge: edge crossing pipeline
// Takes one vertex a cycle, forms the edge from the previous vertex and
// decides whether it crosses the ray right of the point. The crossing x
// is never formed: t*|dx| is compared against |r|*d with signs applied.
// ----------------------------------------------------------------------------
module pip_edge (
   input  logic                                clock,
   input  logic                                reset,
   input  pip_pkg::edge_req_type               req,
   input  pip_pkg::vertex_type                 vtx,
   input  logic signed [pip_pkg::COORD_W-1:0]  px,
   input  logic signed [pip_pkg::COORD_W-1:0]  py,
   output pip_pkg::edge_rsp_type               rsp
);

   localparam int CW = pip_pkg::COORD_W;

   pip_pkg::vertex_type prev_ff;

   // stage A: differences and span test
   logic signed [CW:0] ax, ay, bx, by, px_e, py_e;
   logic signed [CW:0] t, d, dx, r;
   logic signed [CW:0] t_adj, d_adj, dx_abs, r_abs;
   logic               in_span;

   // stage B registers
   logic          b_vld_ff, b_vld_in;
   logic          b_span_ff;
   logic [CW-1:0] b_t_ff, b_d_ff, b_dxm_ff, b_rm_ff;
   logic          b_dxn_ff, b_rn_ff;

   // stage C registers
   logic            c_vld_ff;
   logic            c_span_ff;
   logic [2*CW-1:0] c_lhs_ff, c_rhs_ff, c_lhs_in, c_rhs_in;
   logic            c_dxn_ff, c_rn_ff;

   // output registers
   logic o_vld_ff;
   logic o_hit_ff, o_hit_in;
   logic n1, n2, greater;

   always_comb begin
      ax   = $signed({prev_ff.x[CW-1], prev_ff.x});
      ay   = $signed({prev_ff.y[CW-1], prev_ff.y});
      bx   = $signed({vtx.x[CW-1], vtx.x});
      by   = $signed({vtx.y[CW-1], vtx.y});
      px_e = $signed({px[CW-1], px});
      py_e = $signed({py[CW-1], py});
      // a horizontal edge fails both branches
      in_span = (ay < by) ? ((py_e >= ay) && (py_e < by))
                          : ((py_e >= by) && (py_e < ay));
      t  = py_e - ay;
      d  = by - ay;
      dx = bx - ax;
      r  = px_e - ax;
      // orient the edge upward, take the magnitudes of dx and r
      t_adj  = d[CW] ? -t : t;
      d_adj  = d[CW] ? -d : d;
      dx_abs = dx[CW] ? -dx : dx;
      r_abs  = r[CW] ? -r : r;
   end

   assign b_vld_in = req.vld && !req.first;

   // stage B: the two cross products
   assign c_lhs_in = (2*CW)'(b_t_ff) * (2*CW)'(b_dxm_ff);
   assign c_rhs_in = (2*CW)'(b_rm_ff) * (2*CW)'(b_d_ff);

   // stage C: sign-magnitude compare, zero counts as positive
   always_comb begin
      n1 = c_dxn_ff && (c_lhs_ff != '0);
      n2 = c_rn_ff && (c_rhs_ff != '0);
      if (n1 != n2) begin
         greater = n2;
      end else if (!n1) begin
         greater = (c_lhs_ff > c_rhs_ff);
      end else begin
         greater = (c_lhs_ff < c_rhs_ff);
      end
      o_hit_in = c_span_ff && greater;
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
         c_vld_ff <= b_vld_ff;
         o_vld_ff <= c_vld_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req.vld) begin
         prev_ff <= vtx;
      end
      b_span_ff <= in_span;
      b_t_ff    <= t_adj[CW-1:0];
      b_d_ff    <= d_adj[CW-1:0];
      b_dxm_ff  <= dx_abs[CW-1:0];
      b_dxn_ff  <= dx[CW];
      b_rm_ff   <= r_abs[CW-1:0];
      b_rn_ff   <= r[CW];
      c_span_ff <= b_span_ff;
      c_lhs_ff  <= c_lhs_in;
      c_rhs_ff  <= c_rhs_in;
      c_dxn_ff  <= b_dxn_ff;
      c_rn_ff   <= b_rn_ff;
      o_hit_ff  <= o_hit_in;
   end

   assign rsp.busy    = b_vld_ff || c_vld_ff || o_vld_ff;
   assign rsp.hit_vld = o_vld_ff;
   assign rsp.hit     = o_hit_ff;

endmodule

// ===== src/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back: command execution
// Owns the vertex memory. Stores vertices and, for a query, walks the
// polygon one vertex a cycle through the edge pipeline, keeping parity.
// ----------------------------------------------------------------------------
module pip_back #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // command queue
   input  logic                          cmd_empty,
   input  pip_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   input  logic [pip_pkg::VC_W-1:0]      vertex_count,
   // result queue
   input  logic                          res_full,
   output logic                          res_push,
   output logic                          res_inside
);

   localparam int IdxW = $clog2(MAX_VERTICES);
   localparam int CntW = $clog2(MAX_VERTICES + 1);

   pip_pkg::back_state_type state_ff, state_in;
   pip_pkg::vertex_type     pt_ff, pt_in;
   pip_pkg::vertex_type     vtx_mem [MAX_VERTICES];
   pip_pkg::vertex_type     rd_data_ff;
   pip_pkg::edge_req_type   ereq;
   pip_pkg::edge_rsp_type   ersp;

   logic [CntW-1:0] k_ff, k_in;
   logic [CntW-1:0] n_vert;
   logic            par_ff, par_in;
   logic            rd_vld_ff, rd_first_ff;
   logic            rd_en, rd_first;
   logic [IdxW-1:0] rd_addr, wr_addr;
   logic            wr_en;
   logic            busy;

   // vertices in use, saturated at the table size
   assign n_vert = (32'(vertex_count) > 32'(MAX_VERTICES)) ? CntW'(MAX_VERTICES)
                                                           : CntW'(vertex_count);
   assign wr_addr = IdxW'(cmd.vertex_index);
   // the last read returns to vertex 0 to close the polygon
   assign rd_addr = (k_ff == n_vert) ? '0 : k_ff[IdxW-1:0];
   assign busy    = rd_vld_ff || ersp.busy;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      pt_in      = pt_ff;
      par_in     = par_ff ^ (ersp.hit_vld && ersp.hit);
      cmd_pop    = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_first   = 1'b0;
      res_push   = 1'b0;
      res_inside = par_ff;
      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd.kind)
                  pip_pkg::CMD_WRITE: begin
                     cmd_pop = 1'b1;
                     wr_en   = 1'b1;
                  end
                  pip_pkg::CMD_SKIP: begin
                     cmd_pop = 1'b1;
                  end
                  pip_pkg::CMD_PASS: begin
                     if (!res_full) begin
                        cmd_pop    = 1'b1;
                        res_push   = 1'b1;
                        res_inside = 1'b1;
                     end
                  end
                  pip_pkg::CMD_TEST: begin
                     cmd_pop  = 1'b1;
                     pt_in.x  = cmd.coord_x;
                     pt_in.y  = cmd.coord_y;
                     par_in   = 1'b0;
                     k_in     = '0;
                     state_in = (n_vert == '0) ? pip_pkg::ST_DONE : pip_pkg::ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         pip_pkg::ST_WALK: begin
            rd_en    = 1'b1;
            rd_first = (k_ff == '0);
            k_in     = k_ff + CntW'(1);
            if (k_ff == n_vert) begin
               state_in = pip_pkg::ST_DRAIN;
            end
         end
         pip_pkg::ST_DRAIN: begin
            if (!busy) begin
               state_in = pip_pkg::ST_DONE;
            end
         end
         pip_pkg::ST_DONE: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = pip_pkg::ST_IDLE;
            end
         end
         default: state_in = pip_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pip_pkg::ST_IDLE;
         rd_vld_ff <= 1'b0;
         par_ff    <= 1'b0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         par_ff    <= par_in;
         k_ff      <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff       <= pt_in;
      rd_first_ff <= rd_first;
   end

   // vertex memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vtx_mem[wr_addr].x <= cmd.coord_x;
         vtx_mem[wr_addr].y <= cmd.coord_y;
      end
      if (rd_en) begin
         rd_data_ff <= vtx_mem[rd_addr];
      end
   end

   // edge evaluation
   assign ereq.vld   = rd_vld_ff;
   assign ereq.first = rd_first_ff;

   pip_edge u_edge (
      .clock (clock),
      .reset (reset),
      .req   (ereq),
      .vtx   (rd_data_ff),
      .px    (pt_ff.x),
      .py    (pt_ff.y),
      .rsp   (ersp)
   );

endmodule
